>>> hw/rtl/sdrrip_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdrrip_pkg
// Shared types and constants for the SHiP/DRRIP replacement block.
// ---------------------------------------------------------------------------
package sdrrip_pkg;
  localparam int NUM_SETS = 2048;
  localparam int NUM_WAYS = 16;
  localparam int SIGNATURE_W = 6;
  localparam int SEL_BITS = 10;
  localparam int LEADERS = 64;
  localparam int SET_W = $clog2(NUM_SETS);
  localparam int WAY_W = 4;
  localparam int SIG_N = 1 << SIGNATURE_W;
  localparam logic [SEL_BITS-1:0] SEL_MID = SEL_BITS'(1 << (SEL_BITS - 1));
  localparam logic [SEL_BITS-1:0] SEL_MAX = '1;

  typedef enum logic [1:0] {
    OP_FIND = 2'd0,
    OP_UPDATE = 2'd1,
    OP_DECAY = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_MODIFY, ST_DECAY_RD, ST_DECAY_WR
  } state_t;

  // per-way entry: rrpv, reuse count, owner signature (stored as rrpv^3 so 0 = reset)
  typedef struct packed {
    logic [1:0] rrpv_x;
    logic [1:0] reuse;
    logic [SIGNATURE_W-1:0] sig;
  } entry_t;

  typedef entry_t [NUM_WAYS-1:0] row_t;
endpackage

>>> hw/rtl/sdrrip_row_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdrrip_row_ram
// One row per set, registered read, single write port.
// ---------------------------------------------------------------------------
module sdrrip_row_ram (
  input  logic                    clk,
  input  logic                    we,
  input  logic [sdrrip_pkg::SET_W-1:0] waddr,
  input  sdrrip_pkg::row_t        wdata,
  input  logic [sdrrip_pkg::SET_W-1:0] raddr,
  output sdrrip_pkg::row_t        rdata
);
  import sdrrip_pkg::*;
  row_t mem [NUM_SETS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/ship_drrip_dead_block_replacement.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ship_drrip_dead_block_replacement
// SHiP + DRRIP replacement with per-block reuse counters.
// ---------------------------------------------------------------------------
// channel  dir  handshake           ports
// command  in   start & !busy       operation .. random_draw
// result   out  done, one cycle     victim_way, victim_was_invalid
// Find/update: row read, then modify and write back; set row RAM is the limit.
// No-op: acknowledged by done without a row access.
// Decay: one row per cycle across all NUM_SETS rows; signature counters ride the
// first SIG_N rows of the sweep.
// After reset a clearing pass writes every row; busy is high.
// The receiver cannot stall; done pulses once per command.
module ship_drrip_dead_block_replacement (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [10:0] set_index,
  input  logic [3:0]  way_index,
  input  logic        was_hit,
  input  logic [5:0]  pc_signature,
  input  logic [15:0] valid_mask,
  input  logic [4:0]  random_draw,
  output logic        done,
  output logic [3:0]  victim_way,
  output logic        victim_was_invalid
);
  import sdrrip_pkg::*;

  state_t state, state_next;
  logic [SET_W-1:0] ptr, ptr_next, ptr_m1;
  logic [1:0] op_r;
  logic [SET_W-1:0] set_r;
  logic [3:0] way_r;
  logic hit_r;
  logic [5:0] sig_r;
  logic [15:0] valid_r;
  logic [4:0] draw_r;
  logic [SEL_BITS-1:0] psel;
  logic we;
  logic [SET_W-1:0] waddr, raddr;
  row_t wdata, rdata;
  logic [3:0] vw;
  logic vi;

  // signature outcome counters, registered read
  logic [1:0] outc [SIG_N];
  logic [1:0] outc_q;
  logic outc_we;
  logic [SIGNATURE_W-1:0] outc_waddr, outc_raddr;
  logic [1:0] outc_wdata;

  sdrrip_row_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  always_ff @(posedge clk) begin
    if (outc_we) outc[outc_waddr] <= outc_wdata;
    outc_q <= outc[outc_raddr];
  end

  assign ptr_m1 = ptr - 1'b1;

  logic [1:0] rr [NUM_WAYS];
  logic [1:0] mx;
  logic [1:0] role;
  logic [1:0] ins, bim;
  entry_t e;
  always_comb begin
    mx = 2'd0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      rr[i] = rdata[i].rrpv_x ^ 2'd3;
      if (rr[i] > mx) mx = rr[i];
    end
    vw = '0; vi = 1'b0;
    for (int i = NUM_WAYS - 1; i >= 0; i--)
      if (!valid_r[i]) begin vw = WAY_W'(i); vi = 1'b1; end
    if (!vi)
      for (int i = NUM_WAYS - 1; i >= 0; i--)
        if (rr[i] + (2'd3 - mx) == 2'd3) vw = WAY_W'(i);
    role = (set_r < SET_W'(LEADERS / 2)) ? 2'd0 : (set_r < SET_W'(LEADERS)) ? 2'd1 : 2'd2;
    e = rdata[way_r];
    bim = (draw_r == 5'd0) ? 2'd2 : 2'd3;
    if (e.reuse == 2'd0 || outc_q == 2'd0) ins = 2'd3;
    else if (role == 2'd0) ins = 2'd2;
    else if (role == 2'd1) ins = bim;
    else ins = (psel >= SEL_MID) ? 2'd2 : bim;
  end

  always_comb begin
    state_next = state;
    ptr_next = ptr;
    we = 1'b0;
    waddr = set_r;
    raddr = set_r;
    wdata = rdata;
    outc_we = 1'b0;
    outc_waddr = e.sig;
    outc_raddr = ptr[SIGNATURE_W-1:0];
    outc_wdata = outc_q;
    busy = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        we = 1'b1; waddr = ptr; wdata = '0;
        outc_we = (ptr < SET_W'(SIG_N));
        outc_waddr = ptr[SIGNATURE_W-1:0];
        outc_wdata = 2'd1;
        ptr_next = ptr + 1'b1;
        if (ptr == SET_W'(NUM_SETS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        raddr = set_index;
        if (start) begin
          case (operation)
            OP_DECAY: state_next = ST_DECAY_RD;
            OP_NONE:  state_next = ST_IDLE;
            default:  state_next = ST_READ;
          endcase
        end
        ptr_next = '0;
      end
      ST_READ: begin
        // hit bumps the owner's counter, fill checks the access signature
        outc_raddr = hit_r ? e.sig : sig_r;
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        state_next = ST_IDLE;
        if (op_r == OP_FIND && !vi) begin
          we = 1'b1;
          for (int i = 0; i < NUM_WAYS; i++)
            wdata[i].rrpv_x = (rr[i] + (2'd3 - mx)) ^ 2'd3;
        end else if (op_r == OP_UPDATE) begin
          we = 1'b1;
          if (hit_r) begin
            wdata[way_r].rrpv_x = 2'd3;
            if (e.reuse != 2'd3) wdata[way_r].reuse = e.reuse + 2'd1;
            if (outc_q != 2'd3) begin
              outc_we = 1'b1;
              outc_waddr = e.sig;
              outc_wdata = outc_q + 2'd1;
            end
          end else begin
            wdata[way_r].rrpv_x = ins ^ 2'd3;
            wdata[way_r].sig = sig_r;
            wdata[way_r].reuse = 2'd0;
          end
        end
      end
      ST_DECAY_RD: begin
        raddr = ptr; ptr_next = ptr + 1'b1; state_next = ST_DECAY_WR;
      end
      ST_DECAY_WR: begin
        we = 1'b1; waddr = ptr_m1; raddr = ptr;
        for (int i = 0; i < NUM_WAYS; i++)
          if (rdata[i].reuse != 2'd0) wdata[i].reuse = rdata[i].reuse - 2'd1;
        outc_waddr = ptr_m1[SIGNATURE_W-1:0];
        if (ptr_m1 < SET_W'(SIG_N) && outc_q != 2'd0) begin
          outc_we = 1'b1;
          outc_wdata = outc_q - 2'd1;
        end
        ptr_next = ptr + 1'b1;
        if (ptr == '0) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ptr <= '0;
      psel <= SEL_MID;
      done <= 1'b0;
    end else begin
      state <= state_next;
      ptr <= ptr_next;
      done <= 1'b0;
      victim_way <= '0;
      victim_was_invalid <= 1'b0;
      if (state == ST_IDLE && start) begin
        op_r <= operation; set_r <= set_index; way_r <= way_index; hit_r <= was_hit;
        sig_r <= pc_signature; valid_r <= valid_mask; draw_r <= random_draw;
        if (operation == OP_NONE) done <= 1'b1;
      end
      if (state == ST_MODIFY) begin
        done <= 1'b1;
        if (op_r == OP_FIND) begin
          victim_way <= vw; victim_was_invalid <= vi;
        end
        if (op_r == OP_UPDATE && hit_r) begin
          if (role == 2'd0 && psel != SEL_MAX) psel <= psel + 1'b1;
          if (role == 2'd1 && psel != '0) psel <= psel - 1'b1;
        end
      end
      if (state == ST_DECAY_WR && ptr == '0) done <= 1'b1;
    end
  end
endmodule
